@@ rtl/sipmac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipmac_pkg
// shared types and constants of the keyed siphash mac
// ----------------------------------------------------------------------------
package sipmac_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned TAIL_W  = 3;
	localparam int unsigned ROUND_W = 4;
	localparam int unsigned REG_W   = 2;

	// lane init constants
	localparam logic [WORD_W-1:0] INIT_C0 = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] INIT_C1 = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] INIT_C2 = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] INIT_C3 = 64'h7465646279746573;

	localparam logic [WORD_W-1:0] FIN_MARK = 64'h00000000000000ff;

	// reset round counts
	localparam logic [ROUND_W-1:0] C_RESET = 4'd2;
	localparam logic [ROUND_W-1:0] D_RESET = 4'd4;

	// register indexes
	localparam logic [REG_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [REG_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [REG_W-1:0] REG_C_ROUNDS = 2'd2;
	localparam logic [REG_W-1:0] REG_D_ROUNDS = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] v0;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] v2;
		logic [WORD_W-1:0] v3;
	} lanes_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_MIX,
		ST_FIN,
		ST_EMIT
	} state_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic idle;      // ready for a new word
		logic round;     // apply one sipround to the lanes
		logic mix;       // fold the block into v0
		logic last_blk;  // block being processed is the final one
		logic emit;      // write the hash to the output register and rekey
	} ctl_t;

endpackage : sipmac_pkg
`default_nettype wire

@@ rtl/sipmac_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipmac channel interfaces
// valid/ready channels for message words and hash results
// ----------------------------------------------------------------------------
interface sipmac_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] message_word;
	logic        last_word;
	logic [2:0]  tail_count;

	modport source (output valid, output message_word, output last_word,
		output tail_count, input ready);
	modport sink (input valid, input message_word, input last_word,
		input tail_count, output ready);
endinterface : sipmac_in_if

interface sipmac_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface : sipmac_out_if
`default_nettype wire

@@ rtl/siphash_keyed_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// siphash_keyed_mac
// keyed siphash-c-d mac over little-endian 64-bit message words
// ----------------------------------------------------------------------------
//
// channel   dir  handshake        payload
// msg_in    in   valid / ready    message_word[63:0], last_word, tail_count[2:0]
// hash_out  out  valid / ready    hash_value[63:0]
// cfg       in   cfg_we           cfg_index[1:0], cfg_data[63:0]
//
// a word steps through accept, c siprounds and mix; a last word adds
// d siprounds and an emit step. the single sipround unit applies one
// round per cycle.
// msg_in.ready is high only while the sequencer is idle.
// a finished hash sits in the output register; the next message runs
// meanwhile and only its emit step waits for hash_out.ready.
// reset loads the lanes from an all-zero key with c=2, d=4.
//
module siphash_keyed_mac (
	input  var logic                            clk,
	input  var logic                            arst_n,
	sipmac_in_if.sink                           msg_in,
	sipmac_out_if.source                        hash_out,
	input  var logic                            cfg_we,
	input  var logic [sipmac_pkg::REG_W-1:0]    cfg_index,
	input  var logic [sipmac_pkg::WORD_W-1:0]   cfg_data
);

	// configuration
	logic [63:0] key_lo_q, key_hi_q;
	logic [sipmac_pkg::ROUND_W-1:0] c_q, d_q;

	// hash state
	sipmac_pkg::lanes_t lanes_q, lanes_rnd;
	logic [63:0] blk_q;
	logic [sipmac_pkg::LEN_W-1:0] len_q;

	// output register
	logic [63:0] hash_q;
	logic        out_valid_q;

	sipmac_pkg::ctl_t ctl;
	logic in_fire, out_free, key_wr;
	logic [sipmac_pkg::LEN_W-1:0] total;
	logic [63:0] blk_in;

	assign in_fire  = msg_in.valid && ctl.idle;
	assign out_free = !out_valid_q || hash_out.ready;
	assign key_wr   = cfg_we && ((cfg_index == sipmac_pkg::REG_KEY_LOW)
		|| (cfg_index == sipmac_pkg::REG_KEY_HIGH));

	assign msg_in.ready      = ctl.idle;
	assign hash_out.valid      = out_valid_q;
	assign hash_out.hash_value = hash_q;

	// block formation: keep the tail bytes, length mod 256 in the top byte
	always_comb begin
		total = len_q + {5'd0, msg_in.tail_count};
		blk_in = msg_in.message_word;
		if (msg_in.last_word) begin
			for (int i = 0; i < 8; i++) begin
				if (i >= int'(msg_in.tail_count)) begin
					blk_in[i*8 +: 8] = 8'd0;
				end
			end
			blk_in[63:56] = total;
		end
	end

	sipmac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_last  (msg_in.last_word),
		.out_free (out_free),
		.c_rounds (c_q),
		.d_rounds (d_q),
		.ctl      (ctl)
	);

	sipmac_round u_round (
		.lanes      (lanes_q),
		.lanes_next (lanes_rnd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			c_q      <= sipmac_pkg::C_RESET;
			d_q      <= sipmac_pkg::D_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sipmac_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data;
				sipmac_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
				sipmac_pkg::REG_C_ROUNDS: c_q      <= cfg_data[sipmac_pkg::ROUND_W-1:0];
				sipmac_pkg::REG_D_ROUNDS: d_q      <= cfg_data[sipmac_pkg::ROUND_W-1:0];
				default: ;
			endcase
		end
	end

	// lanes and length; a key write or an emit reloads from the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q.v0 <= sipmac_pkg::INIT_C0;
			lanes_q.v1 <= sipmac_pkg::INIT_C1;
			lanes_q.v2 <= sipmac_pkg::INIT_C2;
			lanes_q.v3 <= sipmac_pkg::INIT_C3;
			len_q      <= '0;
		end else begin
			priority if (key_wr) begin
				// new key value comes straight from the write data
				lanes_q.v0 <= ((cfg_index == sipmac_pkg::REG_KEY_LOW) ? cfg_data : key_lo_q)
					^ sipmac_pkg::INIT_C0;
				lanes_q.v1 <= ((cfg_index == sipmac_pkg::REG_KEY_HIGH) ? cfg_data : key_hi_q)
					^ sipmac_pkg::INIT_C1;
				lanes_q.v2 <= ((cfg_index == sipmac_pkg::REG_KEY_LOW) ? cfg_data : key_lo_q)
					^ sipmac_pkg::INIT_C2;
				lanes_q.v3 <= ((cfg_index == sipmac_pkg::REG_KEY_HIGH) ? cfg_data : key_hi_q)
					^ sipmac_pkg::INIT_C3;
				len_q      <= '0;
			end else if (ctl.emit) begin
				lanes_q.v0 <= key_lo_q ^ sipmac_pkg::INIT_C0;
				lanes_q.v1 <= key_hi_q ^ sipmac_pkg::INIT_C1;
				lanes_q.v2 <= key_lo_q ^ sipmac_pkg::INIT_C2;
				lanes_q.v3 <= key_hi_q ^ sipmac_pkg::INIT_C3;
				len_q      <= '0;
			end else if (in_fire) begin
				lanes_q.v3 <= lanes_q.v3 ^ blk_in;
				if (!msg_in.last_word) begin
					len_q <= len_q + 8'd8;
				end
			end else if (ctl.round) begin
				lanes_q <= lanes_rnd;
			end else if (ctl.mix) begin
				lanes_q.v0 <= lanes_q.v0 ^ blk_q;
				if (ctl.last_blk) begin
					// finalization marker
					lanes_q.v2 <= lanes_q.v2 ^ sipmac_pkg::FIN_MARK;
				end
			end else begin
				lanes_q <= lanes_q;
			end
		end
	end

	// held block, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_q <= blk_in;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (hash_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			hash_q <= lanes_q.v0 ^ lanes_q.v1 ^ lanes_q.v2 ^ lanes_q.v3;
		end
	end

endmodule : siphash_keyed_mac
`default_nettype wire

@@ rtl/sipmac_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipmac_round
// one siphash round over the four lanes
// ----------------------------------------------------------------------------
module sipmac_round (
	input  var sipmac_pkg::lanes_t lanes,
	output var sipmac_pkg::lanes_t lanes_next
);

	logic [63:0] a0, a1, a2, a3;
	logic [63:0] b0, b1, b2, b3;

	always_comb begin
		// first half
		a0 = lanes.v0 + lanes.v1;
		a1 = {lanes.v1[50:0], lanes.v1[63:51]} ^ a0;
		a0 = {a0[31:0], a0[63:32]};
		a2 = lanes.v2 + lanes.v3;
		a3 = {lanes.v3[47:0], lanes.v3[63:48]} ^ a2;
		// second half
		b0 = a0 + a3;
		b3 = {a3[42:0], a3[63:43]} ^ b0;
		b2 = a2 + a1;
		b1 = {a1[46:0], a1[63:47]} ^ b2;
		b2 = {b2[31:0], b2[63:32]};
		lanes_next.v0 = b0;
		lanes_next.v1 = b1;
		lanes_next.v2 = b2;
		lanes_next.v3 = b3;
	end

endmodule : sipmac_round
`default_nettype wire

@@ rtl/sipmac_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipmac_ctrl
// sequencer stepping compression, finalization and emit
// ----------------------------------------------------------------------------
module sipmac_ctrl (
	input  var logic                             clk,
	input  var logic                             arst_n,
	input  var logic                             in_fire,
	input  var logic                             in_last,
	input  var logic                             out_free,
	input  var logic [sipmac_pkg::ROUND_W-1:0]   c_rounds,
	input  var logic [sipmac_pkg::ROUND_W-1:0]   d_rounds,
	output var sipmac_pkg::ctl_t                 ctl
);

	sipmac_pkg::state_t state_q, state_nxt;
	logic [sipmac_pkg::ROUND_W-1:0] cnt_q, cnt_nxt;
	logic last_q;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		unique case (state_q)
			sipmac_pkg::ST_IDLE: begin
				cnt_nxt = '0;
				if (in_fire) begin
					state_nxt = (c_rounds != '0) ? sipmac_pkg::ST_COMP : sipmac_pkg::ST_MIX;
				end
			end
			sipmac_pkg::ST_COMP: begin
				cnt_nxt = cnt_q + 4'd1;
				if (cnt_q == c_rounds - 4'd1) begin
					state_nxt = sipmac_pkg::ST_MIX;
				end
			end
			sipmac_pkg::ST_MIX: begin
				cnt_nxt = '0;
				if (!last_q) begin
					state_nxt = sipmac_pkg::ST_IDLE;
				end else if (d_rounds != '0) begin
					state_nxt = sipmac_pkg::ST_FIN;
				end else begin
					state_nxt = sipmac_pkg::ST_EMIT;
				end
			end
			sipmac_pkg::ST_FIN: begin
				cnt_nxt = cnt_q + 4'd1;
				if (cnt_q == d_rounds - 4'd1) begin
					state_nxt = sipmac_pkg::ST_EMIT;
				end
			end
			sipmac_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nxt = sipmac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = sipmac_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.idle     = (state_q == sipmac_pkg::ST_IDLE);
		ctl.round    = (state_q == sipmac_pkg::ST_COMP) || (state_q == sipmac_pkg::ST_FIN);
		ctl.mix      = (state_q == sipmac_pkg::ST_MIX);
		ctl.last_blk = last_q;
		ctl.emit     = (state_q == sipmac_pkg::ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sipmac_pkg::ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (in_fire) begin
				last_q <= in_last;
			end
		end
	end

endmodule : sipmac_ctrl
`default_nettype wire

@@ rtl/sipmac_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipmac_checker
// port-level checks of the keyed siphash mac
// ----------------------------------------------------------------------------
module sipmac_checker (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        in_valid,
	input  var logic        in_ready,
	input  var logic        out_valid,
	input  var logic        out_ready,
	input  var logic [63:0] hash_value
);

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// a waiting hash word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_value))
		else $error("hash word dropped or changed while stalled");

	// ready drops in the cycle after each accepted word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("ready stayed high right after an accepted word");

	// no hash can appear the cycle after a word is taken
	a_no_early_hash: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !$rose(out_valid))
		else $error("hash word appeared one cycle after accept");

endmodule : sipmac_checker

bind siphash_keyed_mac sipmac_checker u_sipmac_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (msg_in.valid),
	.in_ready   (msg_in.ready),
	.out_valid  (hash_out.valid),
	.out_ready  (hash_out.ready),
	.hash_value (hash_out.hash_value)
);
`default_nettype wire

@@ bench/tb_siphash_keyed_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_siphash_keyed_mac
// self-checking bench for the keyed siphash mac: a shadow model tracks the
// lanes word by word, every hash leaving the block is compared with the
// oldest predicted one, while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_siphash_keyed_mac;

	typedef logic [sipmac_pkg::WORD_W-1:0] lane_word_t;

	typedef struct {
		lane_word_t                    data;
		logic                          last;
		logic [sipmac_pkg::TAIL_W-1:0] tail;
	} msg_word_t;

	localparam lane_word_t  ALL_ONES      = '1;
	// settle time for a word still in flight, sized for c = d = 15
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned IDLE_PCT      = 12;
	localparam int unsigned CALM_FROM     = 1500;
	localparam int unsigned CALM_TO       = 5000;
	localparam int unsigned HOLD_AT       = 40;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned RAND_PHASES   = 8;
	localparam int unsigned PHASE_WORDS   = 229;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [sipmac_pkg::REG_W-1:0]  cfg_index;
	logic [sipmac_pkg::WORD_W-1:0] cfg_data;

	sipmac_in_if  msg_ch ();
	sipmac_out_if hash_ch ();

	siphash_keyed_mac i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_in    (msg_ch),
		.hash_out  (hash_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the key, round counts, lanes and running length
	lane_word_t                     key_lo;
	lane_word_t                     key_hi;
	logic [sipmac_pkg::ROUND_W-1:0] c_rounds;
	logic [sipmac_pkg::ROUND_W-1:0] d_rounds;
	lane_word_t                     v0, v1, v2, v3;
	logic [sipmac_pkg::LEN_W-1:0]   msg_len;

	msg_word_t   word_backlog[$];     // words waiting to be offered
	lane_word_t  expected_digests[$]; // hashes predicted, not yet seen
	lane_word_t  digest_want;
	int unsigned mismatch_count;
	int unsigned digests_seen;
	int unsigned hold_left;
	int unsigned cyc = 0;
	logic        calm;

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// a stretch with no random idling on either side
	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	// ------------------------------------------------------------------
	// sipround predictor
	// ------------------------------------------------------------------
	function automatic lane_word_t rotl(lane_word_t x, int unsigned s);
		return (x << s) | (x >> (sipmac_pkg::WORD_W - s));
	endfunction

	function automatic void sip_round();
		v0 = v0 + v1;
		v1 = rotl(v1, 13);
		v1 = v1 ^ v0;
		v0 = rotl(v0, 32);
		v2 = v2 + v3;
		v3 = rotl(v3, 16);
		v3 = v3 ^ v2;
		v0 = v0 + v3;
		v3 = rotl(v3, 21);
		v3 = v3 ^ v0;
		v2 = v2 + v1;
		v1 = rotl(v1, 17);
		v1 = v1 ^ v2;
		v2 = rotl(v2, 32);
	endfunction

	// lanes back to their keyed start, length cleared
	function automatic void sip_rekey();
		v0 = key_lo ^ sipmac_pkg::INIT_C0;
		v1 = key_hi ^ sipmac_pkg::INIT_C1;
		v2 = key_lo ^ sipmac_pkg::INIT_C2;
		v3 = key_hi ^ sipmac_pkg::INIT_C3;
		msg_len = '0;
	endfunction

	function automatic void sip_compress(lane_word_t m);
		v3 = v3 ^ m;
		for (int unsigned r = 0; r < c_rounds; r++)
			sip_round();
		v0 = v0 ^ m;
	endfunction

	// one accepted word; a last word closes the message and yields a hash
	function automatic void sip_absorb(lane_word_t data, logic last,
			logic [sipmac_pkg::TAIL_W-1:0] tail);
		logic [sipmac_pkg::LEN_W-1:0] total;
		lane_word_t                   mask;
		if (!last) begin
			sip_compress(data);
			msg_len = msg_len + 8'd8;
		end else begin
			total = msg_len + sipmac_pkg::LEN_W'(tail);
			// bytes above the tail count are garbage and must not leak in
			mask = (tail == '0) ? '0 : (ALL_ONES >> (sipmac_pkg::WORD_W - 8 * tail));
			sip_compress((data & mask) | {total, 56'd0});
			v2 = v2 ^ sipmac_pkg::FIN_MARK;
			for (int unsigned r = 0; r < d_rounds; r++)
				sip_round();
			expected_digests.push_back(v0 ^ v1 ^ v2 ^ v3);
			sip_rekey();
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic lane_word_t rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic void push_word(lane_word_t data, logic last,
			logic [sipmac_pkg::TAIL_W-1:0] tail);
		msg_word_t w;
		w.data = data;
		w.last = last;
		w.tail = tail;
		word_backlog.push_back(w);
	endfunction

	// register write; only ever issued while the block is idle, so the
	// shadow state can follow at once
	task automatic cfg_write(logic [sipmac_pkg::REG_W-1:0] idx, lane_word_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			sipmac_pkg::REG_KEY_LOW: begin
				key_lo = value;
				sip_rekey();
			end
			sipmac_pkg::REG_KEY_HIGH: begin
				key_hi = value;
				sip_rekey();
			end
			sipmac_pkg::REG_C_ROUNDS: c_rounds = value[sipmac_pkg::ROUND_W-1:0];
			sipmac_pkg::REG_D_ROUNDS: d_rounds = value[sipmac_pkg::ROUND_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// round counts carry random upper bits, which the block must drop
	task automatic set_rounds(logic [sipmac_pkg::ROUND_W-1:0] c,
			logic [sipmac_pkg::ROUND_W-1:0] d);
		cfg_write(sipmac_pkg::REG_C_ROUNDS,
			{(sipmac_pkg::WORD_W - sipmac_pkg::ROUND_W)'(rnd64()), c});
		cfg_write(sipmac_pkg::REG_D_ROUNDS,
			{(sipmac_pkg::WORD_W - sipmac_pkg::ROUND_W)'(rnd64()), d});
	endtask

	// every word taken, every hash seen, then time for a trailing
	// non-last word to finish its rounds
	task automatic drain();
		while (word_backlog.size() != 0 || expected_digests.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic lane_word_t pick_key();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ALL_ONES;
			default: return rnd64();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// word driver: offers the backlog front, holds it until taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid        <= 1'b0;
			msg_ch.message_word <= '0;
			msg_ch.last_word    <= 1'b0;
			msg_ch.tail_count   <= '0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				sip_absorb(msg_ch.message_word, msg_ch.last_word, msg_ch.tail_count);
				void'(word_backlog.pop_front());
			end
			// a word on offer and not taken stays as it is
			if (!msg_ch.valid || msg_ch.ready) begin
				if (word_backlog.size() != 0 &&
						(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					msg_ch.valid        <= 1'b1;
					msg_ch.message_word <= word_backlog[0].data;
					msg_ch.last_word    <= word_backlog[0].last;
					msg_ch.tail_count   <= word_backlog[0].tail;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// hash monitor: checks each hash, stalls at random, and once holds
	// off long enough for the block to back up into its input
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_ch.ready <= 1'b0;
		end else begin
			if (hash_ch.valid && hash_ch.ready) begin
				if (expected_digests.size() == 0) begin
					mismatch_count++;
					$display("%0t: hash with none expected: expected none, got %h",
						$time, hash_ch.hash_value);
				end else begin
					digest_want = expected_digests.pop_front();
					if (hash_ch.hash_value !== digest_want) begin
						mismatch_count++;
						$display("%0t: hash_value mismatch: expected %h, got %h",
							$time, digest_want, hash_ch.hash_value);
					end
				end
				digests_seen++;
				if (digests_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				hash_ch.ready <= 1'b0;
			end else begin
				hash_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------
	// reset, configuration and the word stream
	// ------------------------------------------------------------------
	initial begin
		int unsigned n_full;
		int unsigned phase_words;
		logic [sipmac_pkg::ROUND_W-1:0] c_pick;
		logic [sipmac_pkg::ROUND_W-1:0] d_pick;

		msg_ch.valid        = 1'b0;
		msg_ch.message_word = '0;
		msg_ch.last_word    = 1'b0;
		msg_ch.tail_count   = '0;
		hash_ch.ready       = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		mismatch_count      = 0;
		digests_seen        = 0;
		hold_left           = 0;

		// reset state: all-zero key, standard round counts
		key_lo   = '0;
		key_hi   = '0;
		c_rounds = sipmac_pkg::C_RESET;
		d_rounds = sipmac_pkg::D_RESET;
		sip_rekey();

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, reset settings ---
		push_word(ALL_ONES, 1'b1, 3'd0);  // empty message, all garbage
		push_word(ALL_ONES, 1'b1, 3'd7);
		push_word(rnd64(), 1'b1, 3'd1);
		push_word('0, 1'b0, 3'd7);        // tail count on a full word is ignored
		push_word(ALL_ONES, 1'b0, 3'd5);
		push_word(ALL_ONES, 1'b1, 3'd3);
		push_word(rnd64(), 1'b1, 3'd2);
		push_word(rnd64(), 1'b1, 3'd4);
		push_word(rnd64(), 1'b1, 3'd5);
		push_word(rnd64(), 1'b1, 3'd6);
		push_word(64'h0706050403020100, 1'b0, 3'd0);
		push_word('0, 1'b1, 3'd0);
		drain();

		// --- all-ones low key, no rounds at all ---
		cfg_write(sipmac_pkg::REG_KEY_LOW, ALL_ONES);
		set_rounds(4'd0, 4'd0);
		push_word(rnd64(), 1'b1, 3'd0);
		push_word(rnd64(), 1'b0, 3'd3);
		push_word(rnd64(), 1'b1, 3'd7);
		drain();

		// --- key write drops a half-done message ---
		push_word(rnd64(), 1'b0, 3'd0);
		drain();
		cfg_write(sipmac_pkg::REG_KEY_HIGH, ALL_ONES);
		set_rounds(4'd15, 4'd15);
		push_word(ALL_ONES, 1'b0, 3'd0);
		push_word(ALL_ONES, 1'b1, 3'd7);
		drain();

		// --- round count change in the middle of a message keeps the lanes ---
		push_word(rnd64(), 1'b0, 3'd0);
		drain();
		cfg_write(sipmac_pkg::REG_C_ROUNDS,
			{(sipmac_pkg::WORD_W - sipmac_pkg::ROUND_W)'(rnd64()), 4'd1});
		push_word(rnd64(), 1'b1, 3'd4);
		drain();

		// --- random messages over several settings ---
		for (int unsigned p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin c_pick = sipmac_pkg::C_RESET; d_pick = sipmac_pkg::D_RESET; end
				1: begin c_pick = 4'd0;    d_pick = 4'd0;    end
				2: begin c_pick = 4'd15;   d_pick = 4'd15;   end
				3: begin c_pick = 4'd0;    d_pick = 4'd15;   end
				4: begin c_pick = 4'd15;   d_pick = 4'd0;    end
				5: begin c_pick = 4'd1;    d_pick = 4'd1;    end
				default: begin
					c_pick = sipmac_pkg::ROUND_W'($urandom_range(0, 15));
					d_pick = sipmac_pkg::ROUND_W'($urandom_range(0, 15));
				end
			endcase
			cfg_write(sipmac_pkg::REG_KEY_LOW, pick_key());
			cfg_write(sipmac_pkg::REG_KEY_HIGH, pick_key());
			set_rounds(c_pick, d_pick);

			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				// now and then a message past 256 bytes so the length wraps
				n_full = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 40)
					: $urandom_range(0, 5);
				for (int unsigned i = 0; i < n_full; i++)
					push_word(rnd64(), 1'b0, sipmac_pkg::TAIL_W'($urandom_range(0, 7)));
				push_word(rnd64(), 1'b1, sipmac_pkg::TAIL_W'($urandom_range(0, 7)));
				phase_words += n_full + 1;
			end
			// sometimes leave a message unfinished for the next key write to drop
			if ($urandom_range(0, 2) == 0) begin
				n_full = $urandom_range(1, 2);
				for (int unsigned i = 0; i < n_full; i++)
					push_word(rnd64(), 1'b0, sipmac_pkg::TAIL_W'($urandom_range(0, 7)));
			end
			drain();
		end

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule : tb_siphash_keyed_mac
